// ===== hw/rtl/ntd_pkg.sv =====
// Package for the nested priority task dispatcher: widths, codes, state types.
// No dependencies.
package ntd_pkg;
	localparam int SLOT_COUNT_DEF = 64;
	localparam int NEST_LIMIT_DEF = 16;
	localparam int STAMP_W = 64;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_DISPATCH = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;

	localparam logic [2:0] ST_ADDED = 3'd0;
	localparam logic [2:0] ST_NULL = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_DISPATCHED = 3'd3;
	localparam logic [2:0] ST_NONE = 3'd4;
	localparam logic [2:0] ST_FINISHED = 3'd5;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_READ  = 6'b000100,
		S_WAIT  = 6'b001000,
		S_APPLY = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;      // capture input beat, reset scan index
		logic scan_step; // examine one slot and advance
		logic rd_best;   // issue read of winning slot
		logic apply;     // commit state change and build result
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} stat_t;
endpackage

// ===== hw/rtl/nested_priority_task_dispatcher_unit.sv =====
// Top level of the nested priority task dispatcher: controller plus datapath.
// Depends on ntd_pkg, ntd_ctrl, ntd_dpath.
//
//  channel | dir | tdata (low bit up)                                   | tuser
//  s_axis  | in  | callback_id, arg_word, task_priority, finish_slot     | kind
//  m_axis  | out | slot_index, out_callback, out_arg, out_priority,      | status
//          |     | nest_depth                                           |
//
// One beat at a time: a dispatch scans the slot RAM, reading one slot per cycle
// (add searches the used flags and stops at the first free slot). s_axis_tready is
// low from acceptance until the result beat is taken; a stalled m_axis holds the
// result.
// arst_n clears flags, counters and the nesting depth at once; no clearing pass.
module nested_priority_task_dispatcher_unit #(
	parameter int SLOT_COUNT = ntd_pkg::SLOT_COUNT_DEF,
	parameter int NEST_LIMIT = ntd_pkg::NEST_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,  // callback_id, arg_word, task_priority, finish_slot
	input  logic [1:0]  s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // slot_index, out_callback, out_arg, out_priority, nest_depth
	output logic [2:0]  m_axis_tuser   // status
);
	import ntd_pkg::*;
	cmd_t cmd;
	stat_t stat;
	logic busy;
	logic [5:0] slot_index;
	logic [15:0] out_callback;
	logic [31:0] out_arg;
	logic signed [31:0] out_priority;
	logic [4:0] nest_depth;

	assign s_axis_tready = !busy;

	ntd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_axis_tvalid && s_axis_tready),
		.out_fire(m_axis_tvalid && m_axis_tready),
		.stat(stat), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
	);

	ntd_dpath #(.SLOT_COUNT(SLOT_COUNT), .NEST_LIMIT(NEST_LIMIT)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.kind(s_axis_tuser),
		.callback_id(s_axis_tdata[15:0]),
		.arg_word(s_axis_tdata[47:16]),
		.task_priority(s_axis_tdata[79:48]),
		.finish_slot(s_axis_tdata[85:80]),
		.status(m_axis_tuser),
		.slot_index(slot_index), .out_callback(out_callback), .out_arg(out_arg),
		.out_priority(out_priority), .nest_depth(nest_depth)
	);

	assign m_axis_tdata = {3'd0, nest_depth, out_priority, out_arg, out_callback, slot_index};
endmodule

// ===== hw/rtl/ntd_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module ntd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/ntd_ctrl.sv =====
// Controller state machine of the dispatcher: sequences capture, scan, read, apply.
// Depends on ntd_pkg.
module ntd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          out_fire,
	input  ntd_pkg::stat_t stat,
	output ntd_pkg::cmd_t  cmd,
	output logic          busy,
	output logic          out_valid
);
	import ntd_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) begin
					cmd.scan_step = 1'b0;
					cmd.rd_best = 1'b1;
					state_d = S_READ;
				end
			end
			// keep the winning slot on the read port until apply
			S_READ: begin
				cmd.rd_best = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				cmd.apply = 1'b1;
				state_d = S_APPLY;
			end
			S_APPLY: state_d = S_OUT;
			S_OUT: if (out_fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
endmodule

// ===== hw/rtl/ntd_dpath.sv =====
// Datapath of the dispatcher: slot flags, slot RAM, linear slot scan, nest stack.
// Depends on ntd_pkg and ntd_ram.
module ntd_dpath #(
	parameter int SLOT_COUNT = ntd_pkg::SLOT_COUNT_DEF,
	parameter int NEST_LIMIT = ntd_pkg::NEST_LIMIT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ntd_pkg::cmd_t  cmd,
	output ntd_pkg::stat_t stat,
	input  logic [1:0]    kind,
	input  logic [15:0]   callback_id,
	input  logic [31:0]   arg_word,
	input  logic signed [31:0] task_priority,
	input  logic [5:0]    finish_slot,
	output logic [2:0]    status,
	output logic [5:0]    slot_index,
	output logic [15:0]   out_callback,
	output logic [31:0]   out_arg,
	output logic signed [31:0] out_priority,
	output logic [4:0]    nest_depth
);
	import ntd_pkg::*;
	localparam int SW = $clog2(SLOT_COUNT);
	localparam int NW = (NEST_LIMIT > 1) ? $clog2(NEST_LIMIT) : 1;
	localparam int DW = $clog2(NEST_LIMIT + 1);
	localparam int RW = 32 + STAMP_W + 16 + 32;

	logic [SLOT_COUNT-1:0] used_q, ready_q;
	logic [1:0]  kind_q;
	logic [15:0] cb_q;
	logic [31:0] arg_q, prio_q;
	logic [5:0]  fslot_q;
	logic [SW:0] idx_q;
	logic        found_q;
	logic [SW-1:0] best_q;
	logic [31:0] bprio_q;
	logic [STAMP_W-1:0] bstamp_q, arrival_q;
	logic [DW-1:0] depth_q;
	logic [31:0] stack_q [NEST_LIMIT];

	// scan reads slot RAM at idx; data returns next cycle (pipelined by one)
	logic [SW:0] cmp_idx_q;
	logic        cmp_v_q;
	logic [RW-1:0] rdata;
	logic [SW-1:0] raddr;
	logic        we;
	logic [SW-1:0] waddr;

	assign raddr = cmd.rd_best ? best_q : idx_q[SW-1:0];
	assign we = cmd.apply && kind_q == KIND_ADD && cb_q != 16'd0 && found_q;
	assign waddr = best_q;

	ntd_ram #(.WIDTH(RW), .DEPTH(SLOT_COUNT)) u_slots (
		.clk(clk), .we(we), .waddr(waddr),
		.wdata({prio_q, arrival_q, cb_q, arg_q}),
		.raddr(raddr), .rdata(rdata)
	);

	logic [31:0] r_prio;
	logic [STAMP_W-1:0] r_stamp;
	logic [15:0] r_cb;
	logic [31:0] r_arg;
	assign {r_prio, r_stamp, r_cb, r_arg} = rdata;

	logic [SW-1:0] cmp_slot;
	logic beats, add_mode;
	assign cmp_slot = cmp_idx_q[SW-1:0];
	assign add_mode = (kind_q == KIND_ADD);
	assign beats = ({~r_prio[31], r_prio[30:0]} > {~bprio_q[31], bprio_q[30:0]}) ||
		(r_prio == bprio_q && r_stamp < bstamp_q);

	// done after the last compare; adds stop early, other kinds at once
	assign stat.scan_done = (kind_q != KIND_DISPATCH && !add_mode) ||
		(add_mode && (found_q || cb_q == 16'd0 || (cmp_v_q && cmp_idx_q == SW'(0) + (SW+1)'(SLOT_COUNT - 1)))) ||
		(!cmp_v_q && idx_q == (SW+1)'(SLOT_COUNT) && cmp_idx_q == (SW+1)'(SLOT_COUNT));

	logic [31:0] top;
	logic outrank;
	assign top = stack_q[NW'(depth_q - DW'(1))];
	assign outrank = (depth_q == '0) ||
		({~bprio_q[31], bprio_q[30:0]} > {~top[31], top[30:0]});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind; cb_q <= callback_id; arg_q <= arg_word;
			prio_q <= task_priority; fslot_q <= finish_slot;
		end
		if (cmd.scan_step && cmp_v_q && !add_mode && ready_q[cmp_slot] &&
				(!found_q || beats)) begin
			bprio_q <= r_prio; bstamp_q <= r_stamp;
		end
		if (cmd.apply) begin
			out_callback <= 16'd0; out_arg <= 32'd0; out_priority <= 32'sd0;
			slot_index <= 6'd0; status <= ST_NONE;
			unique case (kind_q)
				KIND_ADD: begin
					if (cb_q == 16'd0) status <= ST_NULL;
					else if (!found_q) status <= ST_FULL;
					else begin
						status <= ST_ADDED; slot_index <= 6'(best_q);
					end
				end
				KIND_DISPATCH: begin
					if (found_q && outrank) begin
						status <= ST_DISPATCHED; slot_index <= 6'(best_q);
						out_callback <= r_cb; out_arg <= r_arg; out_priority <= r_prio;
					end
				end
				KIND_FINISH: begin
					status <= ST_FINISHED; slot_index <= fslot_q;
				end
				default: status <= ST_NONE;
			endcase
		end
		if (cmd.apply && kind_q == KIND_DISPATCH && found_q && outrank &&
				depth_q < DW'(NEST_LIMIT))
			stack_q[NW'(depth_q)] <= bprio_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0; ready_q <= '0; arrival_q <= '0; depth_q <= '0;
			idx_q <= '0; cmp_idx_q <= '0; cmp_v_q <= 1'b0; found_q <= 1'b0;
			best_q <= '0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0; cmp_v_q <= 1'b0; found_q <= 1'b0; best_q <= '0;
				cmp_idx_q <= '0;
			end
			if (cmd.scan_step) begin
				if (add_mode) begin
					// free search uses flags only
					if (!found_q && idx_q < (SW+1)'(SLOT_COUNT)) begin
						if (!used_q[idx_q[SW-1:0]]) begin
							found_q <= 1'b1; best_q <= idx_q[SW-1:0];
						end
						idx_q <= idx_q + 1'b1;
					end
					cmp_v_q <= 1'b1; cmp_idx_q <= idx_q;
				end else begin
					cmp_v_q <= idx_q < (SW+1)'(SLOT_COUNT);
					cmp_idx_q <= idx_q;
					if (idx_q < (SW+1)'(SLOT_COUNT)) idx_q <= idx_q + 1'b1;
					if (cmp_v_q && ready_q[cmp_slot] && (!found_q || beats)) begin
						found_q <= 1'b1; best_q <= cmp_slot;
					end
				end
			end
			if (cmd.apply) begin
				unique case (kind_q)
					KIND_ADD: if (cb_q != 16'd0 && found_q) begin
						used_q[best_q] <= 1'b1; ready_q[best_q] <= 1'b1;
						arrival_q <= arrival_q + 1'b1;
					end
					KIND_DISPATCH: if (found_q && outrank) begin
						ready_q[best_q] <= 1'b0;
						if (depth_q < DW'(NEST_LIMIT)) depth_q <= depth_q + 1'b1;
					end
					KIND_FINISH: begin
						if (depth_q != '0) depth_q <= depth_q - 1'b1;
						if (32'(fslot_q) < SLOT_COUNT) begin
							used_q[SW'(fslot_q)] <= 1'b0;
							ready_q[SW'(fslot_q)] <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign nest_depth = 5'(depth_q);
endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the nested priority task dispatcher unit.
// Depends on ntd_pkg and nested_priority_task_dispatcher_unit; predicts each result beat.
module testbench;
	import ntd_pkg::*;

	localparam int SLOTS = 64;
	localparam int NEST = 16;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] cb;
		logic [31:0] arg;
		logic [31:0] prio;
		logic [5:0]  fslot;
	} job_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot;
		logic [15:0] cb;
		logic [31:0] arg;
		logic [31:0] prio;
		logic [4:0]  depth;
	} verdict_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [87:0] s_axis_tdata = '0;  // callback_id, arg_word, task_priority, finish_slot
	logic [1:0] s_axis_tuser = '0;   // kind
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [95:0] m_axis_tdata;       // slot_index, out_callback, out_arg, out_priority, nest_depth
	logic [2:0] m_axis_tuser;        // status

	nested_priority_task_dispatcher_unit dut (.*);

	always #1 clk = ~clk;

	// predictor state
	bit          used_q[SLOTS];
	bit          ready_q[SLOTS];
	logic [31:0] prio_q[SLOTS];
	logic [63:0] stamp_q[SLOTS];
	logic [15:0] cb_q[SLOTS];
	logic [31:0] arg_q[SLOTS];
	logic [63:0] arrivals;
	logic [31:0] nest_prio[NEST];
	int          nest_depth;

	job_t     pending_jobs[$];
	verdict_t expected_verdicts[$];
	int       errors = 0, checked = 0, dispatched = 0, added = 0;
	int       idle_in = 0, stall_out = 0, hold_off = 0;
	longint   cycles = 0;

	function automatic verdict_t dispatch_predict(job_t j);
		verdict_t v;
		int best;
		v = '0;
		best = -1;
		if (j.kind == KIND_ADD) begin
			if (j.cb == 0) begin
				v.status = ST_NULL;
			end else begin
				v.status = ST_FULL;
				for (int i = 0; i < SLOTS; i++) begin
					if (!used_q[i]) begin
						used_q[i] = 1; ready_q[i] = 1;
						prio_q[i] = j.prio; stamp_q[i] = arrivals;
						arrivals++;
						cb_q[i] = j.cb; arg_q[i] = j.arg;
						v.status = ST_ADDED; v.slot = 6'(i);
						break;
					end
				end
			end
		end else if (j.kind == KIND_DISPATCH) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (ready_q[i] && (best < 0 || $signed(prio_q[i]) > $signed(prio_q[best]) ||
						(prio_q[i] == prio_q[best] && stamp_q[i] < stamp_q[best])))
					best = i;
			end
			if (best >= 0 && nest_depth > 0 &&
					$signed(prio_q[best]) <= $signed(nest_prio[nest_depth-1]))
				best = -1;
			if (best < 0) begin
				v.status = ST_NONE;
			end else begin
				ready_q[best] = 0;
				if (nest_depth < NEST) begin
					nest_prio[nest_depth] = prio_q[best];
					nest_depth++;
				end
				v.status = ST_DISPATCHED; v.slot = 6'(best);
				v.cb = cb_q[best]; v.arg = arg_q[best]; v.prio = prio_q[best];
			end
		end else if (j.kind == KIND_FINISH) begin
			if (nest_depth > 0) nest_depth--;
			used_q[j.fslot] = 0; ready_q[j.fslot] = 0;
			v.status = ST_FINISHED; v.slot = j.fslot;
		end else begin
			v.status = ST_NONE;
		end
		v.depth = 5'(nest_depth);
		return v;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h (result %0d)", what, got, want, checked);
	endtask

	function automatic job_t mk(logic [1:0] k, logic [15:0] c, logic [31:0] a,
			logic [31:0] p, logic [5:0] f);
		job_t j;
		j.kind = k; j.cb = c; j.arg = a; j.prio = p; j.fslot = f;
		return j;
	endfunction

	function automatic logic [31:0] rand_prio();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom;
			default: return $signed($urandom_range(0, 14)) - 7;
		endcase
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_jobs.size() > 0 && $urandom_range(0, 99) >= idle_in) begin
					job_t j;
					j = pending_jobs.pop_front();
					expected_verdicts.push_back(dispatch_predict(j));
					s_axis_tdata <= {2'b00, j.fslot, j.prio, j.arg, j.cb};
					s_axis_tuser <= j.kind;
					s_axis_tvalid <= 1;
				end else begin
					s_axis_tvalid <= 0;
				end
			end
			m_axis_tready <= (hold_off == 0) && ($urandom_range(0, 99) >= stall_out);
		end
	end

	// long receiver hold-off
	always @(posedge clk) if (hold_off > 0) hold_off <= hold_off - 1;

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			verdict_t want, got;
			got = {m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[21:6], m_axis_tdata[53:22],
				m_axis_tdata[85:54], m_axis_tdata[90:86]};
			if (expected_verdicts.size() == 0) begin
				report("unexpected beat", got.status, 0);
			end else begin
				want = expected_verdicts.pop_front();
				if (got.status != want.status) report("status", got.status, want.status);
				if (got.slot != want.slot) report("slot_index", got.slot, want.slot);
				if (got.cb != want.cb) report("out_callback", got.cb, want.cb);
				if (got.arg != want.arg) report("out_arg", got.arg, want.arg);
				if (got.prio != want.prio) report("out_priority", got.prio, want.prio);
				if (got.depth != want.depth) report("nest_depth", got.depth, want.depth);
				if (want.status == ST_DISPATCHED) dispatched++;
				if (want.status == ST_ADDED) added++;
			end
			checked++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic drain();
		wait (pending_jobs.size() == 0 && !s_axis_tvalid && expected_verdicts.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 40)
				pending_jobs.push_back(mk(KIND_ADD, ($urandom_range(0, 20) == 0) ? 16'd0 :
					16'($urandom), $urandom, rand_prio(), 6'($urandom)));
			else if (r < 70)
				pending_jobs.push_back(mk(KIND_DISPATCH, 16'($urandom), $urandom, $urandom,
					6'($urandom)));
			else if (r < 97)
				pending_jobs.push_back(mk(KIND_FINISH, 16'($urandom), $urandom, $urandom,
					$urandom_range(0, 15) == 0 ? 6'($urandom) : 6'($urandom_range(0, 11))));
			else
				pending_jobs.push_back(mk(2'd3, 16'($urandom), $urandom, $urandom,
					6'($urandom)));
		end
	endtask

	initial begin
		int phase_idle[4] = '{0, 80, 0, 35};
		int phase_stall[4] = '{0, 0, 80, 35};
		for (int i = 0; i < SLOTS; i++) begin
			used_q[i] = 0; ready_q[i] = 0;
		end
		arrivals = 0; nest_depth = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// directed: null, extremes, ties, preemption, unknown kind
		pending_jobs.push_back(mk(KIND_DISPATCH, 0, 0, 0, 0));
		pending_jobs.push_back(mk(KIND_ADD, 16'd0, 32'hffff_ffff, 32'h7fff_ffff, 0));
		pending_jobs.push_back(mk(KIND_ADD, 16'hffff, 32'hffff_ffff, 32'h8000_0000, 6'h3f));
		pending_jobs.push_back(mk(KIND_ADD, 16'h0001, 32'h0, 32'h0000_0005, 0));
		pending_jobs.push_back(mk(KIND_ADD, 16'h0002, 32'h1, 32'h0000_0005, 0));
		pending_jobs.push_back(mk(KIND_ADD, 16'h0003, 32'h2, 32'h7fff_ffff, 0));
		pending_jobs.push_back(mk(KIND_DISPATCH, 0, 0, 0, 0));
		pending_jobs.push_back(mk(KIND_DISPATCH, 0, 0, 0, 0));
		pending_jobs.push_back(mk(KIND_FINISH, 0, 0, 0, 6'd3));
		pending_jobs.push_back(mk(KIND_DISPATCH, 0, 0, 0, 0));
		pending_jobs.push_back(mk(KIND_DISPATCH, 0, 0, 0, 0));
		pending_jobs.push_back(mk(KIND_FINISH, 0, 0, 0, 6'd40));
		pending_jobs.push_back(mk(KIND_FINISH, 0, 0, 0, 6'd1));
		pending_jobs.push_back(mk(KIND_FINISH, 0, 0, 0, 6'd2));
		pending_jobs.push_back(mk(KIND_FINISH, 0, 0, 0, 6'd0));
		pending_jobs.push_back(mk(2'd3, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 6'h3f));
		drain();

		// nest past the stack limit with rising priorities, then fill and overflow the pool
		for (int i = 0; i < 20; i++) begin
			pending_jobs.push_back(mk(KIND_ADD, 16'(i + 1), $urandom, 32'(i), 6'd0));
			pending_jobs.push_back(mk(KIND_DISPATCH, 16'd0, 32'd0, 32'd0, 6'd0));
		end
		for (int i = 20; i < 66; i++)
			pending_jobs.push_back(mk(KIND_ADD, 16'(i + 1), $urandom, 32'(i), 6'd0));
		for (int i = 0; i < 64; i++)
			pending_jobs.push_back(mk(KIND_FINISH, 16'd0, 32'd0, 32'd0, 6'(i)));
		pending_jobs.push_back(mk(KIND_FINISH, 0, 0, 0, 0));
		drain();

		for (int p = 0; p < 4; p++) begin
			idle_in = phase_idle[p];
			stall_out = phase_stall[p];
			queue_random(300);
			if (p == 0) begin
				hold_off = 400;
			end
			drain();
		end
		idle_in = 0; stall_out = 0;
		queue_random(80);
		drain();

		$display("covered %0d results: %0d adds, %0d dispatches, full pool and deep nesting",
			checked, added, dispatched);
		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end
endmodule
